>>> src/bal_pkg.sv
// Package for the bounded array list unit: sizes, operation and status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package bal_pkg;

	localparam int DEPTH = 16;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int DW    = 32;
	localparam int KW    = 3;
	localparam int POSW  = 4;
	localparam int CAPW  = 5;
	localparam int STW   = 2;

	localparam logic [CAPW-1:0] CAP_RESET = CAPW'(16);

	typedef enum logic [KW-1:0] {
		K_APPEND = 3'd0,
		K_SET    = 3'd1,
		K_INSERT = 3'd2,
		K_GET    = 3'd3,
		K_REMOVE = 3'd4
	} kind_t;

	typedef enum logic [STW-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		AS_POS,
		AS_COUNT,
		AS_IDX,
		AS_IDX_DN,
		AS_IDX_UP
	} addr_sel_t;

	typedef enum logic [2:0] {
		IX_HOLD,
		IX_LOAD_COUNT,
		IX_LOAD_POS,
		IX_DEC,
		IX_INC
	} idx_op_t;

	typedef enum logic [1:0] {
		CN_HOLD,
		CN_INC,
		CN_DEC
	} cnt_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_READ,
		S_UP_RD,
		S_UP_WR,
		S_UP_FIN,
		S_DN_RD,
		S_DN_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic      load_req;
		logic      mem_re;
		logic      mem_we;
		logic      wdata_from_mem;
		addr_sel_t addr_sel;
		idx_op_t   idx_op;
		cnt_op_t   cnt_op;
		logic      set_status;
		status_t   status_val;
		logic      clr_dout;
		logic      cap_dout;
		logic      load_rsp;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [KW-1:0] kind;
		logic          pos_bad;
		logic          full;
		logic          empty;
		logic          up_more;
		logic          dn_more;
		logic          dn_more_next;
		logic          rsp_busy;
	} dp_stat_t;

endpackage

>>> src/bal_if.sv
// Channel interfaces for the bounded array list unit: request, result and capacity write.
// Depends on bal_pkg for field widths.
interface bal_req_if;
	logic                             valid;
	logic                             ready;
	logic [bal_pkg::KW-1:0]           kind;
	logic [bal_pkg::POSW-1:0]         position;
	logic signed [bal_pkg::DW-1:0]    data_in;

	modport source (output valid, kind, position, data_in, input ready);
	modport sink (input valid, kind, position, data_in, output ready);
endinterface

interface bal_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [bal_pkg::STW-1:0]          status;
	logic signed [bal_pkg::DW-1:0]    data_out;
	logic [bal_pkg::CAPW-1:0]         entry_total;

	modport source (output valid, status, data_out, entry_total, input ready);
	modport sink (input valid, status, data_out, entry_total, output ready);
endinterface

interface bal_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [bal_pkg::CAPW-1:0]         data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> src/bal_dp.sv
// Datapath of the bounded array list unit: request registers, entry memory,
// count, shift index, capacity register and the result register.
// Depends on bal_pkg.
module bal_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bal_pkg::ctrl_cmd_t            cmd,
	output bal_pkg::dp_stat_t             stat,
	input  logic                          req_valid,
	input  logic [bal_pkg::KW-1:0]        req_kind,
	input  logic [bal_pkg::POSW-1:0]      req_position,
	input  logic signed [bal_pkg::DW-1:0] req_data_in,
	input  logic                          cfg_we,
	input  logic [bal_pkg::CAPW-1:0]      cfg_data,
	input  logic                          rsp_ready,
	output logic                          rsp_valid,
	output logic [bal_pkg::STW-1:0]       rsp_status,
	output logic signed [bal_pkg::DW-1:0] rsp_data_out,
	output logic [bal_pkg::CAPW-1:0]      rsp_entry_total
);

	logic [bal_pkg::KW-1:0]     kind_q;
	logic [bal_pkg::POSW-1:0]   pos_q;
	logic [bal_pkg::DW-1:0]     data_q;
	logic [bal_pkg::CW-1:0]     count_q;
	logic [bal_pkg::AW-1:0]     idx_q;
	logic [bal_pkg::CAPW-1:0]   cap_q;
	bal_pkg::status_t           status_q;
	logic [bal_pkg::DW-1:0]     dout_q;
	logic [bal_pkg::DW-1:0]     rdata_q;
	logic [bal_pkg::DW-1:0]     mem_q [bal_pkg::DEPTH];
	logic                       rsp_valid_q;
	logic [bal_pkg::STW-1:0]    rsp_status_q;
	logic [bal_pkg::DW-1:0]     rsp_data_q;
	logic [bal_pkg::CAPW-1:0]   rsp_total_q;

	logic [bal_pkg::AW-1:0]     addr;
	logic [bal_pkg::DW-1:0]     wdata;
	logic [bal_pkg::CAPW:0]     cap_eff;
	logic [bal_pkg::CW:0]       pos_ext;
	logic [bal_pkg::CW:0]       idx_ext;
	logic [bal_pkg::CW:0]       count_ext;

	// The request registers load only on an accepted transaction.
	logic load_req;
	assign load_req = cmd.load_req && req_valid;

	always_comb begin
		unique case (cmd.addr_sel)
			bal_pkg::AS_POS:    addr = bal_pkg::AW'(pos_q);
			bal_pkg::AS_COUNT:  addr = count_q[bal_pkg::AW-1:0];
			bal_pkg::AS_IDX:    addr = idx_q;
			bal_pkg::AS_IDX_DN: addr = idx_q - 1'b1;
			bal_pkg::AS_IDX_UP: addr = idx_q + 1'b1;
			default:            addr = idx_q;
		endcase
	end

	assign wdata = cmd.wdata_from_mem ? rdata_q : data_q;

	// A capacity above the depth acts as the depth.
	assign cap_eff   = ({1'b0, cap_q} > (bal_pkg::CAPW + 1)'(bal_pkg::DEPTH))
		? (bal_pkg::CAPW + 1)'(bal_pkg::DEPTH) : {1'b0, cap_q};
	assign pos_ext   = (bal_pkg::CW + 1)'(pos_q);
	assign idx_ext   = (bal_pkg::CW + 1)'(idx_q);
	assign count_ext = {1'b0, count_q};

	always_comb begin
		stat.kind         = kind_q;
		stat.pos_bad      = pos_ext >= count_ext;
		stat.full         = (bal_pkg::CAPW + 1)'(count_q) >= cap_eff;
		stat.empty        = count_q == '0;
		stat.up_more      = (idx_ext - 1'b1) > pos_ext;
		stat.dn_more      = (idx_ext + 1'b1) < count_ext;
		stat.dn_more_next = (idx_ext + 2'd2) < count_ext;
		stat.rsp_busy     = rsp_valid_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem_q[addr] <= wdata;
		end
		if (cmd.mem_re) begin
			rdata_q <= mem_q[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (load_req) begin
			pos_q  <= req_position;
			data_q <= req_data_in;
		end
		if (cmd.clr_dout) begin
			dout_q <= '0;
		end else if (cmd.cap_dout) begin
			dout_q <= rdata_q;
		end
		unique case (cmd.idx_op)
			bal_pkg::IX_LOAD_COUNT: idx_q <= count_q[bal_pkg::AW-1:0];
			bal_pkg::IX_LOAD_POS:   idx_q <= bal_pkg::AW'(pos_q);
			bal_pkg::IX_DEC:        idx_q <= idx_q - 1'b1;
			bal_pkg::IX_INC:        idx_q <= idx_q + 1'b1;
			default:                idx_q <= idx_q;
		endcase
		if (cmd.set_status) begin
			status_q <= cmd.status_val;
		end
		if (cmd.load_rsp) begin
			rsp_status_q <= status_q;
			rsp_data_q   <= dout_q;
			rsp_total_q  <= bal_pkg::CAPW'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= '0;
			count_q     <= '0;
			cap_q       <= bal_pkg::CAP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load_req) begin
				kind_q <= req_kind;
			end
			unique case (cmd.cnt_op)
				bal_pkg::CN_INC: count_q <= count_q + 1'b1;
				bal_pkg::CN_DEC: count_q <= count_q - 1'b1;
				default:         count_q <= count_q;
			endcase
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (cmd.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign rsp_status      = rsp_status_q;
	assign rsp_data_out    = rsp_data_q;
	assign rsp_entry_total = rsp_total_q;

endmodule

>>> src/bal_ctrl.sv
// Controller of the bounded array list unit: decodes each request and steps
// the datapath through reads, entry shifts and the result hand-off.
// Depends on bal_pkg.
module bal_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic               rsp_ready,
	input  bal_pkg::dp_stat_t  stat,
	output bal_pkg::ctrl_cmd_t cmd
);

	bal_pkg::state_t state_q;
	bal_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bal_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d            = state_q;
		req_ready          = 1'b0;
		cmd.load_req       = 1'b0;
		cmd.mem_re         = 1'b0;
		cmd.mem_we         = 1'b0;
		cmd.wdata_from_mem = 1'b0;
		cmd.addr_sel       = bal_pkg::AS_POS;
		cmd.idx_op         = bal_pkg::IX_HOLD;
		cmd.cnt_op         = bal_pkg::CN_HOLD;
		cmd.set_status     = 1'b0;
		cmd.status_val     = bal_pkg::ST_OK;
		cmd.clr_dout       = 1'b0;
		cmd.cap_dout       = 1'b0;
		cmd.load_rsp       = 1'b0;

		unique case (state_q)
			bal_pkg::S_IDLE: begin
				req_ready    = 1'b1;
				cmd.load_req = 1'b1;
				if (req_valid) begin
					state_d = bal_pkg::S_DECIDE;
				end
			end
			bal_pkg::S_DECIDE: begin
				cmd.clr_dout   = 1'b1;
				cmd.set_status = 1'b1;
				state_d        = bal_pkg::S_DONE;
				unique case (stat.kind)
					bal_pkg::K_APPEND: begin
						if (stat.full) begin
							cmd.status_val = bal_pkg::ST_FULL;
						end else begin
							cmd.addr_sel = bal_pkg::AS_COUNT;
							cmd.mem_we   = 1'b1;
							cmd.cnt_op   = bal_pkg::CN_INC;
						end
					end
					bal_pkg::K_SET, bal_pkg::K_GET: begin
						if (stat.pos_bad) begin
							cmd.status_val = bal_pkg::ST_RANGE;
						end else begin
							cmd.mem_re = 1'b1;
							state_d    = bal_pkg::S_READ;
						end
					end
					bal_pkg::K_INSERT: begin
						// The position is checked before fullness.
						if (stat.pos_bad) begin
							cmd.status_val = bal_pkg::ST_RANGE;
						end else if (stat.full) begin
							cmd.status_val = bal_pkg::ST_FULL;
						end else begin
							cmd.idx_op = bal_pkg::IX_LOAD_COUNT;
							state_d    = bal_pkg::S_UP_RD;
						end
					end
					bal_pkg::K_REMOVE: begin
						if (stat.empty) begin
							cmd.status_val = bal_pkg::ST_EMPTY;
						end else if (stat.pos_bad) begin
							cmd.status_val = bal_pkg::ST_RANGE;
						end else begin
							cmd.mem_re = 1'b1;
							cmd.idx_op = bal_pkg::IX_LOAD_POS;
							state_d    = bal_pkg::S_READ;
						end
					end
					default: begin
						cmd.status_val = bal_pkg::ST_RANGE;
					end
				endcase
			end
			bal_pkg::S_READ: begin
				cmd.cap_dout = 1'b1;
				state_d      = bal_pkg::S_DONE;
				if (stat.kind == bal_pkg::K_SET) begin
					cmd.mem_we = 1'b1;
				end else if (stat.kind == bal_pkg::K_REMOVE) begin
					if (stat.dn_more) begin
						state_d = bal_pkg::S_DN_RD;
					end else begin
						cmd.cnt_op = bal_pkg::CN_DEC;
					end
				end
			end
			bal_pkg::S_UP_RD: begin
				cmd.addr_sel = bal_pkg::AS_IDX_DN;
				cmd.mem_re   = 1'b1;
				state_d      = bal_pkg::S_UP_WR;
			end
			bal_pkg::S_UP_WR: begin
				cmd.addr_sel       = bal_pkg::AS_IDX;
				cmd.mem_we         = 1'b1;
				cmd.wdata_from_mem = 1'b1;
				cmd.idx_op         = bal_pkg::IX_DEC;
				state_d            = stat.up_more ? bal_pkg::S_UP_RD : bal_pkg::S_UP_FIN;
			end
			bal_pkg::S_UP_FIN: begin
				cmd.mem_we = 1'b1;
				cmd.cnt_op = bal_pkg::CN_INC;
				state_d    = bal_pkg::S_DONE;
			end
			bal_pkg::S_DN_RD: begin
				cmd.addr_sel = bal_pkg::AS_IDX_UP;
				cmd.mem_re   = 1'b1;
				state_d      = bal_pkg::S_DN_WR;
			end
			bal_pkg::S_DN_WR: begin
				cmd.addr_sel       = bal_pkg::AS_IDX;
				cmd.mem_we         = 1'b1;
				cmd.wdata_from_mem = 1'b1;
				cmd.idx_op         = bal_pkg::IX_INC;
				if (stat.dn_more_next) begin
					state_d = bal_pkg::S_DN_RD;
				end else begin
					cmd.cnt_op = bal_pkg::CN_DEC;
					state_d    = bal_pkg::S_DONE;
				end
			end
			bal_pkg::S_DONE: begin
				if (!stat.rsp_busy || rsp_ready) begin
					cmd.load_rsp = 1'b1;
					state_d      = bal_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bal_pkg::S_IDLE;
			end
		endcase
	end

endmodule

>>> src/bounded_array_list_unit.sv
// Top level of the bounded array list unit: joins the controller and datapath
// to the request, result and capacity channels.
// Depends on bal_pkg, bal_if, bal_ctrl and bal_dp.
//
//   channel | role   | payload                           | transaction
//   req     | sink   | kind, position, data_in           | valid && ready
//   rsp     | source | status, data_out, entry_total     | valid && ready
//   cfg     | sink   | data (capacity)                   | valid && ready
//
// After acceptance, append and failed requests pass from the decide state straight to the
// result; get and set first read the entry (set then writes it), and insert and remove
// shift the entries from the position on one at a time; the result is loaded into the
// output register in the final state. The single-port entry memory moves one entry per read/write pair.
// The next request is taken while a result waits, but it holds in its final state
// until the waiting result is taken. Reset clears the count and control and sets the
// capacity to 16; entries are not cleared. Capacity writes are always accepted.
module bounded_array_list_unit (
	input logic          clk,
	input logic          arst_n,
	bal_req_if.sink      req,
	bal_rsp_if.source    rsp,
	bal_cfg_if.sink      cfg
);

	bal_pkg::ctrl_cmd_t cmd;
	bal_pkg::dp_stat_t  stat;

	assign cfg.ready = 1'b1;

	bal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bal_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.req_valid       (req.valid),
		.req_kind        (req.kind),
		.req_position    (req.position),
		.req_data_in     (req.data_in),
		.cfg_we          (cfg.valid),
		.cfg_data        (cfg.data),
		.rsp_ready       (rsp.ready),
		.rsp_valid       (rsp.valid),
		.rsp_status      (rsp.status),
		.rsp_data_out    (rsp.data_out),
		.rsp_entry_total (rsp.entry_total)
	);

endmodule
